// ===== rtl/core/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyword/symbol tokenizer
// Token kinds, token record, character classes and keyword match helpers.
// ----------------------------------------------------------------------------
package kst_pkg;

    // Default counter width (offset, line, symbol length)
    localparam int KST_COUNT_BITS = 16;
    // Width of offset, length and line in a token
    localparam int FIELD_W        = 16;
    // Result queue depth; must hold two tokens of one byte
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

    // Token kinds
    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_INVALID = 4'd1,
        KIND_SYMBOL  = 4'd2,
        KIND_KEYWORD = 4'd3,
        KIND_GREATER = 4'd4,
        KIND_LOWER   = 4'd5,
        KIND_DASH    = 4'd6,
        KIND_OPEN    = 4'd7,
        KIND_CLOSE   = 4'd8
    } t_kind;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_LOWER   = "<";
    localparam logic [7:0] CH_DASH    = "-";
    localparam logic [7:0] CH_OPEN    = "{";
    localparam logic [7:0] CH_CLOSE   = "}";
    localparam logic [7:0] CH_UNDER   = "_";

    // Keyword texts, left aligned and zero padded to five bytes
    localparam logic [39:0] KW_CASE_TXT  = {"case", 8'h00};
    localparam logic [39:0] KW_RUN_TXT   = {"run", 16'h0000};
    localparam logic [39:0] KW_TRACE_TXT = "trace";
    localparam int          KW_NUM       = 3;
    localparam logic [2:0]  KW_LEN [KW_NUM] = '{3'd4, 3'd3, 3'd5};
    localparam logic [2:0]  KW_MAX_LEN   = 3'd5;

    // One result token
    typedef struct packed {
        logic [3:0]         kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] start_line;
        logic               last;
    } t_token;

    // Tokens handed to the result queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_sym_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || (c == CH_UNDER);
    endfunction

    // Kind of a single-byte token
    function automatic t_kind byte_kind(logic [7:0] c);
        t_kind k;
        priority if (c == CH_GREATER) k = KIND_GREATER;
        else if (c == CH_LOWER)       k = KIND_LOWER;
        else if (c == CH_DASH)        k = KIND_DASH;
        else if (c == CH_OPEN)        k = KIND_OPEN;
        else if (c == CH_CLOSE)       k = KIND_CLOSE;
        else                          k = KIND_INVALID;
        return k;
    endfunction

    // Character at position pos of keyword kw (zero past its end)
    function automatic logic [7:0] kw_char(int kw, logic [2:0] pos);
        logic [39:0] txt;
        logic [7:0]  c;
        unique case (kw)
            0:       txt = KW_CASE_TXT;
            1:       txt = KW_RUN_TXT;
            2:       txt = KW_TRACE_TXT;
            default: txt = '0;
        endcase
        unique case (pos)
            3'd0:    c = txt[39:32];
            3'd1:    c = txt[31:24];
            3'd2:    c = txt[23:16];
            3'd3:    c = txt[15:8];
            3'd4:    c = txt[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Narrow keyword candidates with byte c at run position pos
    function automatic logic [2:0] kw_match(logic [2:0] alive, logic pos_ok,
                                            logic [2:0] pos, logic [7:0] c);
        logic [2:0] res;
        res = alive;
        for (int k = 0; k < KW_NUM; k++) begin
            if (!pos_ok || pos >= KW_LEN[k] || kw_char(k, pos) != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/kst_in_if.sv =====
// ----------------------------------------------------------------------------
// kst_in_if: input byte channel
// Valid/ready channel carrying one content byte or the end marker.
// ----------------------------------------------------------------------------
interface kst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_content;

    modport source (output valid, output ch, output end_of_content, input ready);
    modport sink   (input valid, input ch, input end_of_content, output ready);
endinterface

// ===== rtl/core/kst_out_if.sv =====
// ----------------------------------------------------------------------------
// kst_out_if: token channel
// Valid/ready channel carrying one token per transfer.
// ----------------------------------------------------------------------------
interface kst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic [15:0] start_line;
    logic        last;

    modport source (output valid, output kind, output start_offset, output length,
                    output start_line, output last, input ready);
    modport sink   (input valid, input kind, input start_offset, input length,
                    input start_line, input last, output ready);
endinterface

// ===== rtl/core/kst_out_fifo.sv =====
// ----------------------------------------------------------------------------
// kst_out_fifo: token result queue
// Takes up to two tokens per cycle, delivers one per output transfer.
// ----------------------------------------------------------------------------
module kst_out_fifo
    import kst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room2,
    kst_out_if.source o_out
);

    t_token                r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr;
    logic [OUT_PTR_W-1:0]  r_rd;
    logic [OUT_CNT_W-1:0]  r_cnt;
    logic [OUT_PTR_W-1:0]  wr_next;
    logic                  pop;
    t_token                head;

    assign wr_next = r_wr + OUT_PTR_W'(1);
    assign pop     = o_out.valid && o_out.ready;
    assign o_room2 = (r_cnt <= OUT_CNT_W'(OUT_DEPTH - 2));

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OUT_PTR_W'(i_push.cnt);
            r_rd  <= r_rd + OUT_PTR_W'(pop);
            r_cnt <= r_cnt + OUT_CNT_W'(i_push.cnt) - OUT_CNT_W'(pop);
        end
    end

    // Head of queue drives the port
    assign head               = r_mem[r_rd];
    assign o_out.valid        = (r_cnt != '0);
    assign o_out.kind         = head.kind;
    assign o_out.start_offset = head.start_offset;
    assign o_out.length       = head.length;
    assign o_out.start_line   = head.start_line;
    assign o_out.last         = head.last;

endmodule

// ===== rtl/core/keyword_symbol_tokenizer.sv =====
// ----------------------------------------------------------------------------
// keyword_symbol_tokenizer: streaming lexical tokenizer
// Splits a byte stream into symbol, keyword, punctuation and invalid tokens.
// ----------------------------------------------------------------------------
//  Channel | Dir | Transfer carries                  | Per transfer
//  i_in    | in  | ch, end_of_content                | one byte or end marker
//  o_out   | out | kind, start_offset, length,       | one token
//          |     | start_line, last                  |
//
//  One byte is taken per cycle unless the input holds as below; a byte gives
//  zero, one or two tokens. An accepted byte sits in the input register, is
//  classified there and its tokens are written into a four-entry result queue
//  once the queue has room for two tokens; the input register drains only then,
//  so with a stalled output it holds once three or more tokens are queued.
//  Reset (synchronous, active low) clears all counters and empties the queue.
// ----------------------------------------------------------------------------
module keyword_symbol_tokenizer
    import kst_pkg::*;
#(
    parameter int COUNT_BITS = KST_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kst_in_if.sink    i_in,
    kst_out_if.source o_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Input register
    logic                  r_in_valid;
    logic [7:0]            r_ch;
    logic                  r_eoc;

    // Tokenizer state
    logic [COUNT_BITS-1:0] r_offset,  n_offset;
    logic [COUNT_BITS-1:0] r_line,    n_line;
    logic                  r_in_sym,  n_in_sym;
    logic [COUNT_BITS-1:0] r_sym_st,  n_sym_st;
    logic [COUNT_BITS-1:0] r_sym_ln,  n_sym_ln;
    logic [COUNT_BITS-1:0] r_sym_len, n_sym_len;
    logic [2:0]            r_alive,   n_alive;

    logic                  room2;
    logic                  proc;
    logic                  c_space;
    logic                  c_sym;
    logic                  emit_sym;
    logic                  emit_b;
    logic                  is_kw;
    logic [COUNT_BITS-1:0] offset_inc;
    logic [COUNT_BITS-1:0] line_inc;
    logic [COUNT_BITS-1:0] len_inc;
    logic                  pos_ok;
    t_token                sym_tok;
    t_token                b_tok;
    t_push                 push;

    assign proc       = r_in_valid && room2;
    assign i_in.ready = !r_in_valid || room2;

    // Input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch  <= i_in.ch;
            r_eoc <= i_in.end_of_content;
        end
    end

    // Byte class and saturating increments
    assign c_space    = is_space(r_ch);
    assign c_sym      = is_sym_byte(r_ch);
    assign offset_inc = (r_offset == CNT_MAX) ? r_offset : r_offset + CNT_ONE;
    assign line_inc   = (r_line == CNT_MAX) ? r_line : r_line + CNT_ONE;
    assign len_inc    = (r_sym_len == CNT_MAX) ? r_sym_len : r_sym_len + CNT_ONE;
    assign pos_ok     = (r_sym_len < COUNT_BITS'(KW_MAX_LEN));

    // Keyword when a candidate survived and the run has exactly its length
    assign is_kw = (r_alive[0] && r_sym_len == COUNT_BITS'(KW_LEN[0])) ||
                   (r_alive[1] && r_sym_len == COUNT_BITS'(KW_LEN[1])) ||
                   (r_alive[2] && r_sym_len == COUNT_BITS'(KW_LEN[2]));

    // Which tokens this byte produces
    assign emit_sym = r_in_sym && (r_eoc || !c_sym);
    assign emit_b   = r_eoc || (!c_space && !c_sym);

    // Token of the closed symbol run
    always_comb begin
        sym_tok.kind         = is_kw ? KIND_KEYWORD : KIND_SYMBOL;
        sym_tok.start_offset = FIELD_W'(r_sym_st);
        sym_tok.length       = FIELD_W'(r_sym_len);
        sym_tok.start_line   = FIELD_W'(r_sym_ln);
        sym_tok.last         = !emit_b;
    end

    // End token or single-byte token
    always_comb begin
        b_tok.kind         = r_eoc ? KIND_END : byte_kind(r_ch);
        b_tok.start_offset = FIELD_W'(r_offset);
        b_tok.length       = r_eoc ? '0 : FIELD_W'(1);
        b_tok.start_line   = FIELD_W'(r_line);
        b_tok.last         = 1'b1;
    end

    // Push bundle to the result queue
    always_comb begin
        push.cnt  = proc ? {1'b0, emit_sym} + {1'b0, emit_b} : 2'd0;
        push.tok0 = emit_sym ? sym_tok : b_tok;
        push.tok1 = b_tok;
    end

    // Next state
    always_comb begin
        n_offset  = r_offset;
        n_line    = r_line;
        n_in_sym  = r_in_sym;
        n_sym_st  = r_sym_st;
        n_sym_ln  = r_sym_ln;
        n_sym_len = r_sym_len;
        n_alive   = r_alive;
        if (r_eoc) begin
            n_offset  = '0;
            n_line    = '0;
            n_in_sym  = 1'b0;
            n_sym_st  = '0;
            n_sym_ln  = '0;
            n_sym_len = '0;
            n_alive   = 3'b111;
        end else if (r_in_sym && c_sym) begin
            // run continues
            n_alive   = kw_match(r_alive, pos_ok, r_sym_len[2:0], r_ch);
            n_sym_len = len_inc;
            n_offset  = offset_inc;
        end else begin
            n_in_sym = 1'b0;
            if (c_space) begin
                if (r_ch == CH_NEWLINE) begin
                    n_line = line_inc;
                end
            end else if (c_sym) begin
                // run starts
                n_in_sym  = 1'b1;
                n_sym_st  = r_offset;
                n_sym_ln  = r_line;
                n_sym_len = CNT_ONE;
                n_alive   = kw_match(3'b111, 1'b1, 3'd0, r_ch);
            end
            n_offset = offset_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_line    <= '0;
            r_in_sym  <= 1'b0;
            r_sym_st  <= '0;
            r_sym_ln  <= '0;
            r_sym_len <= '0;
            r_alive   <= 3'b111;
        end else if (proc) begin
            r_offset  <= n_offset;
            r_line    <= n_line;
            r_in_sym  <= n_in_sym;
            r_sym_st  <= n_sym_st;
            r_sym_ln  <= n_sym_ln;
            r_sym_len <= n_sym_len;
            r_alive   <= n_alive;
        end
    end

    // Result queue
    kst_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_out   (o_out)
    );

endmodule

// ===== dv/kst_token_checker.sv =====
// ----------------------------------------------------------------------------
// kst_token_checker: token predictor and scoreboard for the tokenizer
// Watches the byte and token channels, predicts the tokens of every accepted
// byte or end marker, and compares each token transfer with the oldest one.
// ----------------------------------------------------------------------------
module kst_token_checker
    import kst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    kst_in_if    i_in_mon,
    kst_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    // Predicted tokenizer state
    logic [FIELD_W-1:0] next_offset;
    logic [FIELD_W-1:0] line_no;
    logic               word_open;
    logic [FIELD_W-1:0] word_start;
    logic [FIELD_W-1:0] word_line;
    logic [FIELD_W-1:0] word_len;
    logic [2:0]         kw_live;

    t_token expected_tokens[$];
    t_token got_tok;
    t_token want_tok;
    int     err_cnt     = 0;
    int     checked_cnt = 0;

    function automatic string keyword_text(int k);
        case (k)
            0:       return "case";
            1:       return "run";
            default: return "trace";
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || (c == CH_UNDER);
    endfunction

    function automatic t_kind punct_kind(logic [7:0] c);
        case (c)
            CH_GREATER: return KIND_GREATER;
            CH_LOWER:   return KIND_LOWER;
            CH_DASH:    return KIND_DASH;
            CH_OPEN:    return KIND_OPEN;
            CH_CLOSE:   return KIND_CLOSE;
            default:    return KIND_INVALID;
        endcase
    endfunction

    // Drop keyword candidates that do not have byte c at position pos
    function automatic logic [2:0] narrow_keywords(logic [2:0] live,
                                                   logic [FIELD_W-1:0] pos,
                                                   logic [7:0] c);
        logic [2:0] res;
        string      s;
        int         p;
        res = live;
        p   = pos;
        for (int k = 0; k < 3; k++) begin
            s = keyword_text(k);
            if (p >= s.len()) begin
                res[k] = 1'b0;
            end else if (s[p] != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // Keyword when a candidate survived and the run has exactly its length
    function automatic t_kind word_kind();
        t_kind k;
        string s;
        k = KIND_SYMBOL;
        for (int i = 0; i < 3; i++) begin
            s = keyword_text(i);
            if (kw_live[i] && int'(word_len) == s.len()) begin
                k = KIND_KEYWORD;
            end
        end
        return k;
    endfunction

    function automatic t_token make_tok(t_kind k, logic [FIELD_W-1:0] off,
                                        logic [FIELD_W-1:0] len,
                                        logic [FIELD_W-1:0] line);
        t_token t;
        t.kind         = k;
        t.start_offset = off;
        t.length       = len;
        t.start_line   = line;
        t.last         = 1'b0;
        return t;
    endfunction

    task automatic clear_state();
        next_offset = '0;
        line_no     = '0;
        word_open   = 1'b0;
        word_start  = '0;
        word_line   = '0;
        word_len    = '0;
        kw_live     = 3'b111;
    endtask

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Tokens caused by one byte or end marker
    task automatic tokenize_byte(logic [7:0] c, logic eoc);
        t_token toks[$];
        if (eoc) begin
            if (word_open) begin
                toks.push_back(make_tok(word_kind(), word_start, word_len, word_line));
            end
            toks.push_back(make_tok(KIND_END, next_offset, '0, line_no));
            clear_state();
        end else if (word_open && is_word_char(c)) begin
            kw_live     = narrow_keywords(kw_live, word_len, c);
            word_len    = bump(word_len);
            next_offset = bump(next_offset);
        end else begin
            // a non-word byte closes the open run first
            if (word_open) begin
                toks.push_back(make_tok(word_kind(), word_start, word_len, word_line));
                word_open = 1'b0;
            end
            if (is_blank(c)) begin
                if (c == CH_NEWLINE) begin
                    line_no = bump(line_no);
                end
            end else if (is_word_char(c)) begin
                word_open  = 1'b1;
                word_start = next_offset;
                word_line  = line_no;
                word_len   = FIELD_W'(1);
                kw_live    = narrow_keywords(3'b111, '0, c);
            end else begin
                toks.push_back(make_tok(punct_kind(c), next_offset, FIELD_W'(1),
                                        line_no));
            end
            next_offset = bump(next_offset);
        end
        if (toks.size() > 0) begin
            toks[toks.size()-1].last = 1'b1;
        end
        foreach (toks[i]) begin
            expected_tokens.push_back(toks[i]);
        end
    endtask

    // Compare token transfers first: they always stem from older bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_tokens.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got_tok.kind         = i_out_mon.kind;
                got_tok.start_offset = i_out_mon.start_offset;
                got_tok.length       = i_out_mon.length;
                got_tok.start_line   = i_out_mon.start_line;
                got_tok.last         = i_out_mon.last;
                if (expected_tokens.size() == 0) begin
                    note_error($sformatf("unexpected token kind %0d off %0d len %0d line %0d",
                               got_tok.kind, got_tok.start_offset, got_tok.length,
                               got_tok.start_line));
                end else begin
                    want_tok = expected_tokens.pop_front();
                    checked_cnt++;
                    if (got_tok !== want_tok) begin
                        note_error($sformatf({"token %0d: expected kind %0d off %0d len %0d ",
                                   "line %0d last %0d, got kind %0d off %0d len %0d ",
                                   "line %0d last %0d"}, checked_cnt,
                                   want_tok.kind, want_tok.start_offset, want_tok.length,
                                   want_tok.start_line, want_tok.last,
                                   got_tok.kind, got_tok.start_offset, got_tok.length,
                                   got_tok.start_line, got_tok.last));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                tokenize_byte(i_in_mon.ch, i_in_mon.end_of_content);
            end
        end
        o_pending <= expected_tokens.size();
        o_errors  <= err_cnt;
        o_checked <= checked_cnt;
    end

endmodule

// ===== dv/tb_keyword_symbol_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_keyword_symbol_tokenizer: testbench top of the keyword/symbol tokenizer
// Feeds directed text and random token-shaped text under varying idle rates
// and a long output hold; the checker scores.
// ----------------------------------------------------------------------------
module tb_keyword_symbol_tokenizer
    import kst_pkg::*;
();

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 570;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;

    kst_in_if  in_ch();
    kst_out_if out_ch();

    int err_cnt;
    int pend_cnt;
    int chk_cnt;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int bytes_sent   = 0;
    int ends_sent    = 0;
    int cycle_cnt    = 0;

    keyword_symbol_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    kst_token_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_ch),
        .i_out_mon (out_ch),
        .o_errors  (err_cnt),
        .o_pending (pend_cnt),
        .o_checked (chk_cnt)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycle_cnt, pend_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // Token receiver: random ready, plus a long hold on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // One transfer on the byte channel, with random idle cycles before it
    task automatic push_item(logic [7:0] c, logic eoc);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.ch             <= c;
        in_ch.end_of_content <= eoc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (eoc) begin
            ends_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(s[i], 1'b0);
        end
    endtask

    task automatic push_end();
        push_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic string kw_word(int k);
        case (k)
            0:       return "case";
            1:       return "run";
            default: return "trace";
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)      return 8'("a" + r);
        else if (r < 52) return 8'("A" + r - 26);
        else if (r < 62) return 8'("0" + r - 52);
        else             return CH_UNDER;
    endfunction

    // Space or newline between words, mostly
    task automatic push_separator();
        if ($urandom_range(99) < 75) begin
            push_item(($urandom_range(3) == 0) ? CH_NEWLINE : 8'h20, 1'b0);
        end
    endtask

    // One random piece of text shaped like real content
    task automatic push_random_piece();
        int    sel;
        int    n;
        string s;
        logic [7:0] blanks [6];
        blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        sel = $urandom_range(99);
        if (sel < 30) begin
            push_text(kw_word($urandom_range(2)));
            push_separator();
        end else if (sel < 45) begin
            // keyword prefix, maybe with one more word byte
            s = kw_word($urandom_range(2));
            n = $urandom_range(s.len(), 1);
            for (int i = 0; i < n; i++) begin
                push_item(s[i], 1'b0);
            end
            if ($urandom_range(1)) begin
                push_item(word_char(), 1'b0);
            end
            push_separator();
        end else if (sel < 60) begin
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++) begin
                push_item(word_char(), 1'b0);
            end
            push_separator();
        end else if (sel < 74) begin
            case ($urandom_range(4))
                0:       push_item(CH_GREATER, 1'b0);
                1:       push_item(CH_LOWER, 1'b0);
                2:       push_item(CH_DASH, 1'b0);
                3:       push_item(CH_OPEN, 1'b0);
                default: push_item(CH_CLOSE, 1'b0);
            endcase
        end else if (sel < 87) begin
            push_item(blanks[$urandom_range(5)], 1'b0);
        end else if (sel < 96) begin
            push_item(8'($urandom_range(255)), 1'b0);
        end else begin
            push_end();
        end
    endtask

    task automatic run_random(int count);
        int start;
        start = bytes_sent + ends_sent;
        while (bytes_sent + ends_sent - start < count) begin
            push_random_piece();
        end
    endtask

    // Stimulus and verdict
    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.ch             <= 8'h00;
        in_ch.end_of_content <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 37;
        snk_idle_pct = 65;

        // Directed: keywords next to punctuation, prefixes, odd bytes,
        // open run flushed by the end marker, then an empty content
        push_text("case{run}trace-ca>_9<");
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h80, 1'b0);
        push_text(" \nx");
        push_end();
        push_end();

        run_random(PHASE_ITEMS);

        src_idle_pct = 65;
        snk_idle_pct = 37;
        run_random(PHASE_ITEMS);

        // No idling; the receiver holds off while bytes keep coming
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        run_random(PHASE_ITEMS);

        push_end();
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes and %0d end markers, checked %0d tokens",
                 bytes_sent, ends_sent, chk_cnt);
        $display("Covered swapped idle rates and a %0d-cycle output hold with a full queue",
                 HOLD_CYCLES);
        if (pend_cnt != 0) begin
            $display("ERROR: %0d expected tokens never arrived", pend_cnt);
        end
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors", err_cnt);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kst_pkg.sv
rtl/core/kst_in_if.sv
rtl/core/kst_out_if.sv
rtl/core/kst_out_fifo.sv
rtl/core/keyword_symbol_tokenizer.sv
dv/kst_token_checker.sv
dv/tb_keyword_symbol_tokenizer.sv
